### rtl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  // Opcodes and length escapes from the frame header
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Event kinds on the result channel
  typedef enum logic [1:0] {
    EV_TEXT_BYTE = 2'd0,
    EV_EMPTY_MSG = 2'd1,
    EV_CLOSE     = 2'd2
  } ev_kind_t;

  // Parser phases, one-hot
  typedef enum logic [6:0] {
    PH_HDR0    = 7'b0000001,
    PH_HDR1    = 7'b0000010,
    PH_EXT16   = 7'b0000100,
    PH_EXT64   = 7'b0001000,
    PH_MASK    = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_IDLE    = 7'b1000000
  } phase_t;

  // Classified event passed from the parser to the output side
  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic        last;
    logic        trunc;
  } evt_t;

endpackage

### rtl/wsdf_in_if.sv
// Input byte channel: valid/ready handshake with raw byte and buffer end flag.
interface wsdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

### rtl/wsdf_out_if.sv
// Result channel: valid/ready handshake with one deframer event.
interface wsdf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] payload_byte;
  logic       message_last;
  logic       truncated;

  modport source (output valid, output event_kind, output payload_byte,
                  output message_last, output truncated, input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input message_last, input truncated, output ready);
endinterface

### rtl/wsdf_front.sv
// Header parser: walks the frame header and classifies each accepted byte.
module wsdf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  input  logic          buffer_end,
  output logic          evt_valid,
  output wsdf_pkg::evt_t evt
);
  import wsdf_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  hcount, hcount_next;
  logic [3:0]  opcode, opcode_next;
  logic        mask_present, mask_present_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] mask_word, mask_word_next;
  logic [1:0]  mask_index, mask_index_next;

  logic        after_len;
  logic        hdr_done;
  logic [6:0]  len7;
  logic [7:0]  key;

  assign len7 = data_byte[6:0];

  // Key byte for the current payload position, big-endian within the word
  always_comb begin
    case (mask_index)
      2'd0:    key = mask_word[31:24];
      2'd1:    key = mask_word[23:16];
      2'd2:    key = mask_word[15:8];
      default: key = mask_word[7:0];
    endcase
  end

  // Next-state and event decode
  always_comb begin
    phase_next        = phase;
    hcount_next       = hcount;
    opcode_next       = opcode;
    mask_present_next = mask_present;
    remaining_next    = remaining;
    mask_word_next    = mask_word;
    mask_index_next   = mask_index;
    after_len         = 1'b0;
    hdr_done          = 1'b0;
    evt_valid         = 1'b0;
    evt               = '0;

    unique case (phase)
      PH_HDR0: begin
        opcode_next     = data_byte[3:0];
        mask_word_next  = '0;
        mask_index_next = '0;
        remaining_next  = '0;
        phase_next      = PH_HDR1;
      end
      PH_HDR1: begin
        mask_present_next = data_byte[7];
        hcount_next       = '0;
        if (len7 == LEN_EXT16) begin
          phase_next = PH_EXT16;
        end else if (len7 == LEN_EXT64) begin
          phase_next = PH_EXT64;
        end else begin
          remaining_next = {57'd0, len7};
          after_len      = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        remaining_next = {remaining[55:0], data_byte};
        hcount_next    = hcount + 4'd1;
        if ((phase == PH_EXT16) ? (hcount == 4'd1) : (hcount == 4'd7)) begin
          after_len = 1'b1;
        end
      end
      PH_MASK: begin
        mask_word_next = {mask_word[23:0], data_byte};
        hcount_next    = hcount + 4'd1;
        if (hcount == 4'd3) begin
          hcount_next = '0;
          hdr_done    = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        mask_index_next = mask_index + 2'd1;
        remaining_next  = remaining - 64'd1;
        evt_valid       = 1'b1;
        evt.kind        = EV_TEXT_BYTE;
        evt.raw         = data_byte;
        evt.key         = key;
        if (remaining == 64'd1) begin
          phase_next = PH_IDLE;
          evt.last   = 1'b1;
        end else begin
          evt.last  = buffer_end;
          evt.trunc = buffer_end;
        end
      end
      PH_IDLE: begin
        // trailing bytes are dropped until buffer end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    // Length known: go on to the mask key or finish the header
    if (after_len) begin
      hcount_next = '0;
      if (mask_present_next) begin
        phase_next = PH_MASK;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: decide what the frame produces
    if (hdr_done) begin
      if (opcode == OP_TEXT) begin
        if (remaining_next == 64'd0) begin
          phase_next = PH_IDLE;
          evt_valid  = 1'b1;
          evt.kind   = EV_EMPTY_MSG;
          evt.last   = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
          if (buffer_end) begin
            evt_valid = 1'b1;
            evt.kind  = EV_EMPTY_MSG;
            evt.last  = 1'b1;
            evt.trunc = 1'b1;
          end
        end
      end else begin
        phase_next = PH_IDLE;
        if (opcode == OP_CLOSE) begin
          evt_valid = 1'b1;
          evt.kind  = EV_CLOSE;
        end
      end
    end

    // Buffer end returns the parser to its starting state
    if (buffer_end) begin
      phase_next        = PH_HDR0;
      hcount_next       = '0;
      opcode_next       = '0;
      mask_present_next = 1'b0;
      remaining_next    = '0;
      mask_word_next    = '0;
      mask_index_next   = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      hcount       <= '0;
      opcode       <= '0;
      mask_present <= 1'b0;
      remaining    <= '0;
      mask_word    <= '0;
      mask_index   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      hcount       <= hcount_next;
      opcode       <= opcode_next;
      mask_present <= mask_present_next;
      remaining    <= remaining_next;
      mask_word    <= mask_word_next;
      mask_index   <= mask_index_next;
    end
  end

endmodule

### rtl/wsdf_fifo.sv
// Small event queue between the parser and the output stage.
module wsdf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wsdf_pkg::evt_t push_data,
  input  logic           pop,
  output wsdf_pkg::evt_t pop_data,
  output logic           full,
  output logic           empty
);
  import wsdf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  evt_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/wsdf_back.sv
// Output stage: unmasks queued events into the result register.
module wsdf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  wsdf_pkg::evt_t q_data,
  output logic           q_pop,
  wsdf_out_if.source     out_ch
);
  import wsdf_pkg::*;

  logic       valid;
  ev_kind_t   kind;
  logic [7:0] payload;
  logic       last;
  logic       trunc;

  // Load whenever the register is free or being drained
  assign q_pop = !q_empty && (!valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (q_pop) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind    <= q_data.kind;
      payload <= q_data.raw ^ q_data.key;
      last    <= q_data.last;
      trunc   <= q_data.trunc;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.event_kind   = kind;
  assign out_ch.payload_byte = payload;
  assign out_ch.message_last = last;
  assign out_ch.truncated    = trunc;

endmodule

### rtl/websocket_frame_deframer_top.sv
// Top level of the WebSocket frame deframer.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    data_byte[7:0], buffer_end
//   out_ch    out   valid/ready    event_kind[1:0], payload_byte[7:0],
//                                  message_last, truncated
//
// One byte is taken every cycle while the queue is not full; the header parser
// decides each byte in the cycle it is accepted, using one 64-bit decrement
// and compare on the length. Results pass the queue, then the output register.
// in_ch.ready drops only when the event queue (QUEUE_DEPTH entries) is full.
// Synchronous reset rst clears the parser, queue and output register.
module websocket_frame_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  wsdf_in_if.sink     in_ch,
  wsdf_out_if.source  out_ch
);
  import wsdf_pkg::*;

  logic take;
  logic evt_valid;
  evt_t evt;
  evt_t q_data;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && !q_full;

  wsdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (in_ch.data_byte),
    .buffer_end (in_ch.buffer_end),
    .evt_valid  (evt_valid),
    .evt        (evt)
  );

  wsdf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take && evt_valid),
    .push_data (evt),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  wsdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
